>>> src/key_debounce_repeat_events_top_macros.svh
// Assertion macros shared by the key debounce RTL
`ifndef KEY_DEBOUNCE_REPEAT_EVENTS_TOP_MACROS_SVH
`define KEY_DEBOUNCE_REPEAT_EVENTS_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define KDRE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kdre check failed");

// Next-cycle implication, checked outside reset
`define KDRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kdre check failed");

`endif

>>> src/kdre_pkg.sv
`timescale 1ns / 1ps
package kdre_pkg;

	localparam int FIELD_W    = 11;
	localparam int NUM_KEYS   = FIELD_W;
	localparam int CNT_W      = 16;
	localparam int AGREE_W    = 3;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [AGREE_W-1:0] AGREE_NEEDED = AGREE_W'(3);
	localparam logic [AGREE_W-1:0] AGREE_CAP    = AGREE_W'(5);

	localparam logic [CNT_W-1:0] DEFAULT_DELAY    = CNT_W'(200);
	localparam logic [CNT_W-1:0] DEFAULT_INTERVAL = CNT_W'(20);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_MASK     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MASK     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = CFG_IDX_W'(3);

	// Pending event codes
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2,
		EV_REPEAT  = 2'd3
	} event_t;

	// Per-key sample and consumed-event bits
	typedef struct packed {
		logic lvl;
		logic clr_press;
		logic clr_rel;
		logic clr_rpt;
	} lane_in_t;

	// Per-key settings
	typedef struct packed {
		logic             is_tog;
		logic             is_rep;
		logic [CNT_W-1:0] delay;
		logic [CNT_W-1:0] interval;
	} lane_cfg_t;

	// Per-key result after the tick
	typedef struct packed {
		logic stable;
		logic press;
		logic rel;
		logic rpt;
	} lane_res_t;

endpackage

>>> src/kdre_if.sv
`timescale 1ns / 1ps
// Scan tick channel
interface kdre_in_if;
	import kdre_pkg::*;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] key_levels;
	logic [FIELD_W-1:0] clear_press_mask;
	logic [FIELD_W-1:0] clear_release_mask;
	logic [FIELD_W-1:0] clear_repeat_mask;
	modport source (output valid, key_levels, clear_press_mask, clear_release_mask,
		clear_repeat_mask, input ready);
	modport sink (input valid, key_levels, clear_press_mask, clear_release_mask,
		clear_repeat_mask, output ready);
endinterface

// Result channel
interface kdre_out_if;
	import kdre_pkg::*;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] stable_levels;
	logic [FIELD_W-1:0] press_flags;
	logic [FIELD_W-1:0] release_flags;
	logic [FIELD_W-1:0] repeat_flags;
	modport source (output valid, stable_levels, press_flags, release_flags,
		repeat_flags, input ready);
	modport sink (input valid, stable_levels, press_flags, release_flags,
		repeat_flags, output ready);
endinterface

// Register write channel
interface kdre_cfg_if;
	import kdre_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/kdre_lane.sv
`timescale 1ns / 1ps
`include "key_debounce_repeat_events_top_macros.svh"
module kdre_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  kdre_pkg::lane_in_t  lin,
	input  kdre_pkg::lane_cfg_t lcfg,
	output kdre_pkg::lane_res_t res
);
	import kdre_pkg::*;

	logic               prev_q, prev_n;
	logic               deb_q, deb_n;
	logic [AGREE_W-1:0] agree_q, agree_n;
	event_t             ev_q, ev_n;
	logic [CNT_W-1:0]   hold_q, hold_n;
	logic [CNT_W-1:0]   gap_q, gap_n;
	logic [CNT_W-1:0]   hold_inc, gap_inc;

	// Next state for one scan tick
	always_comb begin
		ev_n     = ev_q;
		deb_n    = deb_q;
		hold_n   = hold_q;
		gap_n    = gap_q;
		hold_inc = '0;
		gap_inc  = '0;

		// consumed events, only where the type matches
		if ((ev_q == EV_PRESS && lin.clr_press) || (ev_q == EV_RELEASE && lin.clr_rel) ||
				(ev_q == EV_REPEAT && lin.clr_rpt)) begin
			ev_n = EV_NONE;
		end

		// agreement counter, capped
		if (lin.lvl == prev_q) begin
			agree_n = (agree_q < AGREE_CAP) ? agree_q + AGREE_W'(1) : agree_q;
		end else begin
			agree_n = '0;
		end
		prev_n = lin.lvl;

		// stable level change and event latch
		if (agree_n >= AGREE_NEEDED) begin
			if (lin.lvl != deb_q) begin
				deb_n = lin.lvl;
				if (lcfg.is_tog) begin
					ev_n = EV_NONE;
				end else if (!lin.lvl) begin
					ev_n   = EV_PRESS;
					hold_n = '0;
					gap_n  = '0;
				end else begin
					ev_n = EV_RELEASE;
				end
			end
			agree_n = '0;
		end

		// auto-repeat while held; paused while a press is pending
		if (lcfg.is_rep && !deb_n) begin
			if (ev_n != EV_PRESS) begin
				hold_inc = hold_n + CNT_W'(1);
				hold_n   = hold_inc;
				if (hold_inc == lcfg.delay) begin
					ev_n  = EV_REPEAT;
					gap_n = '0;
				end else if (hold_inc > lcfg.delay) begin
					gap_inc = gap_n + CNT_W'(1);
					if (gap_inc >= lcfg.interval) begin
						gap_n = '0;
						ev_n  = EV_REPEAT;
					end else begin
						gap_n = gap_inc;
					end
				end
			end
		end else begin
			hold_n = '0;
			gap_n  = '0;
		end
	end

	assign res.stable = deb_n;
	assign res.press  = (ev_n == EV_PRESS);
	assign res.rel    = (ev_n == EV_RELEASE);
	assign res.rpt    = (ev_n == EV_REPEAT);

	// Per-key state, updated on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b1;
			deb_q   <= 1'b1;
			agree_q <= '0;
			ev_q    <= EV_NONE;
			hold_q  <= '0;
			gap_q   <= '0;
		end else if (advance) begin
			prev_q  <= prev_n;
			deb_q   <= deb_n;
			agree_q <= agree_n;
			ev_q    <= ev_n;
			hold_q  <= hold_n;
			gap_q   <= gap_n;
		end
	end

	`KDRE_ASSERT_NOW(a_agree_capped, clk, arst_n, 1'b1, agree_q <= AGREE_CAP)
	`KDRE_ASSERT_NEXT(a_tog_no_event, clk, arst_n, advance && lcfg.is_tog && ev_q == EV_NONE, ev_q == EV_NONE)
	`KDRE_ASSERT_NEXT(a_no_rep_no_hold, clk, arst_n, advance && !lcfg.is_rep, hold_q == '0 && gap_q == '0)

endmodule

>>> src/kdre_merge.sv
`timescale 1ns / 1ps
`include "key_debounce_repeat_events_top_macros.svh"
module kdre_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  kdre_pkg::lane_res_t lanes [kdre_pkg::NUM_KEYS],
	output logic                can_load,
	kdre_out_if.source          events
);
	import kdre_pkg::*;

	logic               valid_q;
	logic [FIELD_W-1:0] stable_q, press_q, rel_q, rpt_q;
	logic [FIELD_W-1:0] stable_c, press_c, rel_c, rpt_c;

	// Gather lane results into result words
	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			stable_c[k] = lanes[k].stable;
			press_c[k]  = lanes[k].press;
			rel_c[k]    = lanes[k].rel;
			rpt_c[k]    = lanes[k].rpt;
		end
	end

	assign can_load = !valid_q || events.ready;

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (events.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			stable_q <= stable_c;
			press_q  <= press_c;
			rel_q    <= rel_c;
			rpt_q    <= rpt_c;
		end
	end

	assign events.valid         = valid_q;
	assign events.stable_levels = stable_q;
	assign events.press_flags   = press_q;
	assign events.release_flags = rel_q;
	assign events.repeat_flags  = rpt_q;

	`KDRE_ASSERT_NOW(a_load_needs_room, clk, arst_n, load, can_load)
	`KDRE_ASSERT_NEXT(a_load_sets_valid, clk, arst_n, load, valid_q)
	`KDRE_ASSERT_NEXT(a_idle_drains, clk, arst_n, !load && events.ready, !valid_q)

endmodule

>>> src/key_debounce_repeat_events_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Transaction
// keys      in         one scan tick: raw levels and consumed-event masks
// events    out        one result: stable levels and pending event flags
// cfg       in         register write: index, data (always ready)
//
// One scan tick per cycle while keys.ready is high; each key has its own lane, all in step.
// A result appears in the output register the cycle after its tick is taken.
// keys.ready drops only while a result is held and events.ready is low.
// Reset takes every key as released with no event pending.
module key_debounce_repeat_events_top (
	input  logic       clk,
	input  logic       arst_n,
	kdre_in_if.sink    keys,
	kdre_out_if.source events,
	kdre_cfg_if.sink   cfg
);
	import kdre_pkg::*;

	logic               advance;
	logic               can_load;
	logic [FIELD_W-1:0] toggle_q, repeat_q;
	logic [CNT_W-1:0]   delay_q, interval_q;
	lane_res_t          lanes [NUM_KEYS];

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_q   <= '0;
			repeat_q   <= '0;
			delay_q    <= DEFAULT_DELAY;
			interval_q <= DEFAULT_INTERVAL;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TOGGLE_MASK:     toggle_q   <= cfg.data[FIELD_W-1:0];
				REG_REPEAT_MASK:     repeat_q   <= cfg.data[FIELD_W-1:0];
				REG_REPEAT_DELAY:    delay_q    <= cfg.data[CNT_W-1:0];
				REG_REPEAT_INTERVAL: interval_q <= cfg.data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign keys.ready = can_load;
	assign advance    = keys.valid && can_load;

	// One lane per key
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		lane_in_t  lin;
		lane_cfg_t lcfg;

		assign lin.lvl       = keys.key_levels[k];
		assign lin.clr_press = keys.clear_press_mask[k];
		assign lin.clr_rel   = keys.clear_release_mask[k];
		assign lin.clr_rpt   = keys.clear_repeat_mask[k];
		// toggle wins over repeat
		assign lcfg.is_tog   = toggle_q[k];
		assign lcfg.is_rep   = !toggle_q[k] && repeat_q[k];
		assign lcfg.delay    = delay_q;
		assign lcfg.interval = interval_q;

		kdre_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.lin     (lin),
			.lcfg    (lcfg),
			.res     (lanes[k])
		);
	end

	kdre_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.lanes    (lanes),
		.can_load (can_load),
		.events   (events)
	);

endmodule
